>>> rtl/satrc_pkg.sv
// Shared types, constants and register codes for the satellite RC frame decoder.
package satrc_pkg;

    localparam int FRAME_BYTES  = 16;
    localparam int MAX_CHANNELS = 8;
    localparam int POS_W        = $clog2(FRAME_BYTES);
    localparam int CH_IDX_W     = $clog2(MAX_CHANNELS);
    localparam int PAIRS        = (FRAME_BYTES - 2) / 2;
    localparam int CFG_ADDR_W   = 4;

    localparam logic [11:0] VALUE_OFFSET  = 12'd988;
    localparam logic [0:0]  MODE_RESET    = 1'b1;
    localparam logic [11:0] MID_RESET     = 12'd1500;
    localparam logic [23:0] MAP_RESET     = 24'hFAC688;
    localparam logic [15:0] GAP_RESET     = 16'd5000;

    localparam logic [0:0] REQ_BYTE = 1'b0;
    localparam logic [0:0] REQ_READ = 1'b1;

    typedef enum logic [1:0] {
        REG_MODE = 2'd0,
        REG_MID  = 2'd1,
        REG_MAP  = 2'd2,
        REG_GAP  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [0:0]  req_type;
        logic [7:0]  rx_byte;
        logic [31:0] time_us;
        logic [3:0]  channel;
    } t_in_item;

    typedef struct packed {
        logic [11:0] channel_value;
        logic [0:0]  frame_complete;
        logic [0:0]  failsafe_clear;
    } t_out_item;

    typedef struct packed {
        logic [0:0]  resolution_mode;
        logic [11:0] mid_value;
        logic [23:0] channel_map;
        logic [15:0] gap_threshold;
    } t_cfg;

    typedef logic [FRAME_BYTES-1:0][7:0] t_frame;

    // Assembler status toward the channel reader and the result register
    typedef struct packed {
        logic frame_ready;   // ready flag before the current word
        logic data_seen;     // any byte received since reset
        logic ready_after;   // ready flag after the current word
        logic fs_clear;      // current byte filled the last position
    } t_asm_stat;

endpackage

>>> rtl/satrc_cfg.sv
// APB register bank for mode, mid value, channel map and gap threshold.
module satrc_cfg import satrc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.resolution_mode <= MODE_RESET;
            r_cfg.mid_value       <= MID_RESET;
            r_cfg.channel_map     <= MAP_RESET;
            r_cfg.gap_threshold   <= GAP_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MODE: r_cfg.resolution_mode <= pwdata[0:0];
                REG_MID:  r_cfg.mid_value       <= pwdata[11:0];
                REG_MAP:  r_cfg.channel_map     <= pwdata[23:0];
                REG_GAP:  r_cfg.gap_threshold   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MODE: prdata = {31'd0, r_cfg.resolution_mode};
            REG_MID:  prdata = {20'd0, r_cfg.mid_value};
            REG_MAP:  prdata = {8'd0, r_cfg.channel_map};
            REG_GAP:  prdata = {16'd0, r_cfg.gap_threshold};
            default:  prdata = 32'd0;
        endcase
    end

endmodule

>>> rtl/satrc_asm.sv
// Frame assembler: gap detection, byte buffer, write position and ready flag.
module satrc_asm import satrc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_exec,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_frame    o_frame,
    output t_asm_stat o_stat
);

    t_frame            r_buf;
    logic [POS_W-1:0]  r_pos;
    logic [31:0]       r_last_time;
    logic              r_ready;
    logic              r_seen;

    logic [31:0]       interval;
    logic              gap;
    logic [POS_W-1:0]  wr_pos;
    logic              at_last;
    logic              is_byte;

    assign is_byte  = (i_item.req_type == REQ_BYTE);
    assign interval = i_item.time_us - r_last_time;   // modular difference
    assign gap      = interval > {16'd0, i_cfg.gap_threshold};
    assign wr_pos   = gap ? '0 : r_pos;
    assign at_last  = (wr_pos == POS_W'(FRAME_BYTES - 1));

    assign o_frame            = r_buf;
    assign o_stat.frame_ready = r_ready;
    assign o_stat.data_seen   = r_seen;
    assign o_stat.fs_clear    = is_byte && at_last;
    assign o_stat.ready_after = is_byte ? (r_ready || at_last) : 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_last_time <= '0;
            r_ready     <= 1'b0;
            r_seen      <= 1'b0;
        end else if (i_exec) begin
            r_ready <= o_stat.ready_after;
            if (is_byte) begin
                r_last_time <= i_item.time_us;
                r_seen      <= 1'b1;
                if (!at_last) begin
                    r_pos <= wr_pos + POS_W'(1);
                end else begin
                    r_pos <= wr_pos;   // hold on the last slot until a gap
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_exec && is_byte) begin
            r_buf[wr_pos] <= i_item.rx_byte;
        end
    end

endmodule

>>> rtl/satrc_chan.sv
// Channel store: decodes a ready frame into eight values and reads one logical channel.
module satrc_chan import satrc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_exec,
    input  t_in_item    i_item,
    input  t_cfg        i_cfg,
    input  t_frame      i_frame,
    input  t_asm_stat   i_stat,
    output logic [11:0] o_value
);

    logic [MAX_CHANNELS-1:0][10:0] r_store;
    logic [MAX_CHANNELS-1:0][10:0] n_store;
    logic                          is_read;
    logic                          do_decode;
    logic [3:0]                    n_active;
    logic [CH_IDX_W-1:0]           map_idx;
    logic [10:0]                   raw;
    logic [10:0]                   scaled;

    assign is_read   = (i_item.req_type == REQ_READ);
    assign do_decode = is_read && i_stat.frame_ready;
    assign n_active  = i_cfg.resolution_mode[0] ? 4'd8 : 4'd7;

    // Pairs in frame order; a later pair with the same id wins
    always_comb begin
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [3:0]  id;
        logic [10:0] val;
        hi      = '0;
        lo      = '0;
        id      = '0;
        val     = '0;
        n_store = r_store;
        if (do_decode) begin
            for (int p = 0; p < PAIRS; p++) begin
                hi = i_frame[2*p + 2];
                lo = i_frame[2*p + 3];
                if (i_cfg.resolution_mode[0]) begin
                    id  = hi[6:3];
                    val = {hi[2:0], lo};
                end else begin
                    id  = hi[5:2];
                    val = {1'b0, hi[1:0], lo};
                end
                for (int k = 0; k < MAX_CHANNELS; k++) begin
                    if (id < n_active && id == 4'(k)) begin
                        n_store[k] = val;
                    end
                end
            end
        end
    end

    assign map_idx = i_cfg.channel_map[3*i_item.channel[CH_IDX_W-1:0] +: CH_IDX_W];
    assign raw     = n_store[map_idx];
    assign scaled  = i_cfg.resolution_mode[0] ? {1'b0, raw[10:1]} : raw;

    always_comb begin
        if (!is_read) begin
            o_value = 12'd0;
        end else if (i_item.channel >= n_active || !i_stat.data_seen) begin
            o_value = i_cfg.mid_value;
        end else begin
            o_value = VALUE_OFFSET + {1'b0, scaled};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store <= '0;
        end else if (i_exec) begin
            r_store <= n_store;
        end
    end

endmodule

>>> rtl/satellite_rc_frame_decoder_core.sv
// Top level of the satellite RC frame decoder: input register, decode logic, result register.
//
// Each word on the input channel is either a received serial byte (req_type 0) or a
// request to read one logical channel (req_type 1); every word yields exactly one result
// word. A byte word measures the time since the previous byte on the wrapping 32-bit
// microsecond clock; a gap above gap_threshold restarts the frame at position 0. When the
// sixteenth position is written the frame is flagged complete and failsafe_clear pulses;
// further bytes without a gap overwrite that last position. A read word first decodes a
// pending frame (seven byte pairs, channel id plus 10- or 11-bit value) into the channel
// store, then returns 988 plus the mapped channel value (halved in 11-bit mode), or
// mid_value when the channel is outside the mode's range or no byte has arrived yet.
// Throughput is one word per clock when the result side does not stall: the word is
// captured in an input register, all work is done by the gap compare / decode / offset add
// between that register and the result register, which drives o_out_valid. The input
// register moves forward whenever the result register is empty or being drained, so
// the block takes a new word while a finished result waits, if the input register is
// free. Configuration goes over the APB port at byte addresses 0 (mode), 4 (mid value),
// 8 (channel map), 12 (gap threshold); writes are meant for idle periods only.
module satellite_rc_frame_decoder_core import satrc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input words
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    // result words
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    t_cfg        cfg;
    t_frame      frame;
    t_asm_stat   stat;

    // input register
    logic        r_s1_vld;
    t_in_item    r_s1;
    // result register
    logic        r_out_vld;
    t_out_item   r_out;

    logic        exec;      // the captured word is processed this cycle
    logic        in_acc;
    logic [11:0] value;

    assign exec       = r_s1_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_s1_vld && !exec;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    satrc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    satrc_asm u_asm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_exec  (exec),
        .i_item  (r_s1),
        .i_cfg   (cfg),
        .o_frame (frame),
        .o_stat  (stat)
    );

    satrc_chan u_chan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_exec  (exec),
        .i_item  (r_s1),
        .i_cfg   (cfg),
        .i_frame (frame),
        .i_stat  (stat),
        .o_value (value)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (exec) begin
                r_s1_vld <= 1'b0;
            end
            if (exec) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= i_in_data;
        end
        if (exec) begin
            r_out.channel_value  <= value;
            r_out.frame_complete <= stat.ready_after;
            r_out.failsafe_clear <= stat.fs_clear;
        end
    end

    // a waiting word is never dropped while the result side is blocked
    a_hold_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !exec |=> r_s1_vld && $stable(r_s1))
        else $error("input register lost a word while blocked");

    // a read always consumes the pending frame
    a_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec && r_s1.req_type == REQ_READ |=> !stat.frame_ready)
        else $error("frame still flagged ready after a read");

    // failsafe clear only comes with a complete frame
    a_fs_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec && stat.fs_clear |=> r_out.frame_complete && stat.frame_ready)
        else $error("failsafe clear without frame ready");

    // read results carry no failsafe pulse and never a ready frame
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec && r_s1.req_type == REQ_READ |=> !r_out.failsafe_clear && !r_out.frame_complete)
        else $error("read result carries frame flags");

endmodule
